// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the stack block RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset
`define DSUS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define DSUS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dsus_pkg.sv
// ---------------------------------------------------------------------------
// dsus_pkg
// Shared sizes, codes and control structs of the two-stack undo block.
// ---------------------------------------------------------------------------
package dsus_pkg;

    // Stack geometry
    localparam int DEPTH     = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int OUT_CNT_W = 5;
    localparam int CNT_RAW_W = $clog2(DEPTH + 1);
    localparam int CNT_W     = (CNT_RAW_W > OUT_CNT_W) ? CNT_RAW_W : OUT_CNT_W;
    localparam int DATA_W    = 32;

    // Stream widths
    localparam int OP_W       = 3;
    localparam int STAT_W     = 3;
    localparam int S_TDATA_W  = DATA_W;
    localparam int M_FIELDS_W = STAT_W + 3 * DATA_W + 2 + 2 * OUT_CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
    localparam logic [OP_W-1:0] OP_POP     = 3'd1;
    localparam logic [OP_W-1:0] OP_MOVE    = 3'd2;
    localparam logic [OP_W-1:0] OP_RESTORE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_MAIN_EMPTY = 3'd1,
        STAT_AUX_EMPTY  = 3'd2,
        STAT_MAIN_FULL  = 3'd3,
        STAT_AUX_FULL   = 3'd4
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;    // latch the accepted input word
        logic exec;       // apply the operation to the stacks
        logic load_top;   // take the new top from the memory read
        logic load_out;   // move the result into the output register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_read;  // operation uncovers an entry that must be fetched
        logic out_free;   // output register can take a result this cycle
    } dp_sts_t;

endpackage

// File: rtl/dsus_ctrl.sv
// ---------------------------------------------------------------------------
// dsus_ctrl
// Sequencer: accept, execute, optional top fetch, result hand-off.
// ---------------------------------------------------------------------------
module dsus_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  dsus_pkg::dp_sts_t   sts,
    output dsus_pkg::ctrl_cmd_t cmd
);
    import dsus_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_EXEC;
            ST_EXEC:  state_next = sts.need_read ? ST_FETCH : ST_DONE;
            ST_FETCH: state_next = ST_DONE;
            ST_DONE:  if (sts.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Commands
    assign s_tready     = (state_reg == ST_IDLE);
    assign cmd.capture  = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.exec     = (state_reg == ST_EXEC);
    assign cmd.load_top = (state_reg == ST_FETCH);
    assign cmd.load_out = (state_reg == ST_DONE) && sts.out_free;

endmodule

// File: rtl/dsus_dpath.sv
// ---------------------------------------------------------------------------
// dsus_dpath
// Stack memories, counts, cached tops and the output word register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dsus_dpath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dsus_pkg::ctrl_cmd_t            cmd,
    output dsus_pkg::dp_sts_t              sts,
    input  logic [dsus_pkg::OP_W-1:0]      s_op,
    input  logic [dsus_pkg::S_TDATA_W-1:0] s_value,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dsus_pkg::M_TDATA_W-1:0] m_tdata
);
    import dsus_pkg::*;

    // Stack memories
    logic [DATA_W-1:0] main_mem [DEPTH];
    logic [DATA_W-1:0] aux_mem  [DEPTH];

    logic [OP_W-1:0]          op_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [CNT_W-1:0]         main_cnt_reg, main_cnt_next;
    logic [CNT_W-1:0]         aux_cnt_reg,  aux_cnt_next;
    logic [DATA_W-1:0]        main_top_reg, main_top_next;
    logic [DATA_W-1:0]        aux_top_reg,  aux_top_next;
    status_t                  status_reg,   status_next;
    logic [DATA_W-1:0]        removed_reg,  removed_next;
    logic                     rd_main_reg,  rd_main_next;
    logic [DATA_W-1:0]        main_rdata_reg;
    logic [DATA_W-1:0]        aux_rdata_reg;
    logic                     out_valid_reg;
    logic [M_TDATA_W-1:0]     out_data_reg;

    logic             main_empty, main_full, aux_empty, aux_full;
    logic             main_wr, aux_wr;
    logic [IDX_W-1:0] main_wr_idx, aux_wr_idx, rd_idx;
    logic [DATA_W-1:0] wr_data;
    logic             need_read;
    logic [CNT_W-1:0] main_dec, aux_dec;
    logic [CNT_W-1:0] main_idx_cnt, aux_idx_cnt;
    logic             mv, av;
    logic [DATA_W-1:0] mt, at;

    // Input word capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_op;
            val_reg <= s_value;
        end
    end

    assign main_empty   = (main_cnt_reg == '0);
    assign aux_empty    = (aux_cnt_reg == '0);
    assign main_full    = (main_cnt_reg >= CNT_W'(DEPTH));
    assign aux_full     = (aux_cnt_reg >= CNT_W'(DEPTH));
    assign main_dec     = main_cnt_reg - CNT_W'(1);
    assign aux_dec      = aux_cnt_reg - CNT_W'(1);
    assign main_idx_cnt = main_dec - CNT_W'(1);
    assign aux_idx_cnt  = aux_dec - CNT_W'(1);
    assign main_wr_idx  = main_cnt_reg[IDX_W-1:0];
    assign aux_wr_idx   = aux_cnt_reg[IDX_W-1:0];

    // Operation decode and next state
    always_comb begin
        main_cnt_next = main_cnt_reg;
        aux_cnt_next  = aux_cnt_reg;
        main_top_next = main_top_reg;
        aux_top_next  = aux_top_reg;
        status_next   = status_reg;
        removed_next  = removed_reg;
        rd_main_next  = rd_main_reg;
        main_wr       = 1'b0;
        aux_wr        = 1'b0;
        wr_data       = val_reg;
        rd_idx        = main_idx_cnt[IDX_W-1:0];
        need_read     = 1'b0;
        if (cmd.exec) begin
            status_next  = STAT_OK;
            removed_next = '0;
            case (op_reg)
                OP_PUSH: begin
                    if (main_full) begin
                        status_next = STAT_MAIN_FULL;
                    end else begin
                        main_wr       = 1'b1;
                        main_top_next = val_reg;
                        main_cnt_next = main_cnt_reg + CNT_W'(1);
                    end
                end
                OP_POP: begin
                    if (main_empty) begin
                        status_next = STAT_MAIN_EMPTY;
                    end else begin
                        removed_next  = main_top_reg;
                        main_cnt_next = main_dec;
                        rd_main_next  = 1'b1;
                        need_read     = (main_dec != '0);
                    end
                end
                OP_MOVE: begin
                    if (main_empty) begin
                        status_next = STAT_MAIN_EMPTY;
                    end else if (aux_full) begin
                        status_next = STAT_AUX_FULL;
                    end else begin
                        removed_next  = main_top_reg;
                        wr_data       = main_top_reg;
                        aux_wr        = 1'b1;
                        aux_top_next  = main_top_reg;
                        aux_cnt_next  = aux_cnt_reg + CNT_W'(1);
                        main_cnt_next = main_dec;
                        rd_main_next  = 1'b1;
                        need_read     = (main_dec != '0);
                    end
                end
                OP_RESTORE: begin
                    if (aux_empty) begin
                        status_next = STAT_AUX_EMPTY;
                    end else if (main_full) begin
                        status_next = STAT_MAIN_FULL;
                    end else begin
                        removed_next  = aux_top_reg;
                        wr_data       = aux_top_reg;
                        main_wr       = 1'b1;
                        main_top_next = aux_top_reg;
                        main_cnt_next = main_cnt_reg + CNT_W'(1);
                        aux_cnt_next  = aux_dec;
                        rd_main_next  = 1'b0;
                        rd_idx        = aux_idx_cnt[IDX_W-1:0];
                        need_read     = (aux_dec != '0);
                    end
                end
                OP_CLEAR: begin
                    main_cnt_next = '0;
                end
                default: begin
                end
            endcase
        end else if (cmd.load_top) begin
            // Uncovered entry becomes the cached top
            if (rd_main_reg) begin
                main_top_next = main_rdata_reg;
            end else begin
                aux_top_next = aux_rdata_reg;
            end
        end
    end

    // Memory write and registered read, one port each
    always_ff @(posedge aclk) begin
        if (main_wr) begin
            main_mem[main_wr_idx] <= wr_data;
        end
        main_rdata_reg <= main_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (aux_wr) begin
            aux_mem[aux_wr_idx] <= wr_data;
        end
        aux_rdata_reg <= aux_mem[rd_idx];
    end

    // Counts (control state)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_cnt_reg <= '0;
            aux_cnt_reg  <= '0;
        end else begin
            main_cnt_reg <= main_cnt_next;
            aux_cnt_reg  <= aux_cnt_next;
        end
    end

    // Tops and result payload
    always_ff @(posedge aclk) begin
        main_top_reg <= main_top_next;
        aux_top_reg  <= aux_top_next;
        status_reg   <= status_next;
        removed_reg  <= removed_next;
        rd_main_reg  <= rd_main_next;
    end

    // Result word assembly
    assign mv = (main_cnt_reg != '0);
    assign av = (aux_cnt_reg != '0);
    assign mt = mv ? main_top_reg : '0;
    assign at = av ? aux_top_reg : '0;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {{M_PAD_W{1'b0}},
                             aux_cnt_reg[OUT_CNT_W-1:0],
                             main_cnt_reg[OUT_CNT_W-1:0],
                             av, at, mv, mt, removed_reg, status_reg};
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;
    assign sts.need_read = need_read;
    assign sts.out_free  = !out_valid_reg || m_tready;

    // Checks
    `DSUS_ASSERT(a_main_bound, aclk, aresetn, main_cnt_reg <= CNT_W'(DEPTH), "main count over depth")
    `DSUS_ASSERT(a_aux_bound, aclk, aresetn, aux_cnt_reg <= CNT_W'(DEPTH), "aux count over depth")
    `DSUS_ASSERT_NEXT(a_push_inc, aclk, aresetn, cmd.exec && op_reg == OP_PUSH && !main_full, main_cnt_reg == $past(main_cnt_reg) + CNT_W'(1), "push did not grow main stack")
    `DSUS_ASSERT_NEXT(a_fail_hold, aclk, aresetn, cmd.exec && status_next != STAT_OK, $stable(main_cnt_reg) && $stable(aux_cnt_reg) && removed_reg == '0, "failed operation changed state")

endmodule

// File: rtl/dual_stack_with_undo_store.sv
// Each word passes accept, execute, a fetch if an entry is uncovered, and hand-off;
//   the next word is taken only after hand-off. The fetch is the registered read
//   of the stack memory that fetches the newly uncovered top after pop, move or restore.
// A new input word is taken while the previous result still waits in the output register.
// Reset (aresetn low, synchronous) empties both stacks and drops any pending result;
//   memory contents are not cleared and no clearing pass is needed.
// ---------------------------------------------------------------------------
// dual_stack_with_undo_store
// Main and auxiliary stacks of 32-bit words with push, pop, move, restore, clear.
// ---------------------------------------------------------------------------
module dual_stack_with_undo_store (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dsus_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] push_value
    input  logic [dsus_pkg::OP_W-1:0]      s_tuser,  // [2:0] opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] status, [34:3] removed_value, [66:35] main_top, [67] main_valid,
    // [99:68] aux_top, [100] aux_valid, [105:101] main_count,
    // [110:106] aux_count, [111] zero pad
    output logic [dsus_pkg::M_TDATA_W-1:0] m_tdata
);
    import dsus_pkg::*;

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // Sequencer
    dsus_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Stacks and result register
    dsus_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_op     (s_tuser),
        .s_value  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: dv/stack_mirror_pkg.sv
// ---------------------------------------------------------------------------
// stack_mirror_pkg
// Software copy of the main and aux stacks. Every accepted operation word is
// applied to it, and each result word from the block is compared, field by
// field, against the oldest predicted result.
// ---------------------------------------------------------------------------
package stack_mirror_pkg;

    import dsus_pkg::*;

    // One result word, unpacked
    typedef struct {
        status_t             status;
        logic [DATA_W-1:0]   removed;
        logic [DATA_W-1:0]   main_top;
        logic                main_valid;
        logic [DATA_W-1:0]   aux_top;
        logic                aux_valid;
        logic [OUT_CNT_W-1:0] main_count;
        logic [OUT_CNT_W-1:0] aux_count;
    } stack_result_t;

    class stack_mirror;
        logic [DATA_W-1:0] main_words[DEPTH];
        logic [DATA_W-1:0] aux_words[DEPTH];
        int                main_fill = 0;
        int                aux_fill = 0;
        stack_result_t     pending_results[$];
        int                mismatches = 0;
        int                results_seen = 0;

        // Apply one operation to the stacks and queue the result it yields
        function void apply_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] value);
            stack_result_t r;
            r.status  = STAT_OK;
            r.removed = '0;
            case (op)
                OP_PUSH: begin
                    if (main_fill >= DEPTH) begin
                        r.status = STAT_MAIN_FULL;
                    end else begin
                        main_words[main_fill] = value;
                        main_fill++;
                    end
                end
                OP_POP: begin
                    if (main_fill == 0) begin
                        r.status = STAT_MAIN_EMPTY;
                    end else begin
                        main_fill--;
                        r.removed = main_words[main_fill];
                    end
                end
                OP_MOVE: begin
                    // empty main wins over full aux
                    if (main_fill == 0) begin
                        r.status = STAT_MAIN_EMPTY;
                    end else if (aux_fill >= DEPTH) begin
                        r.status = STAT_AUX_FULL;
                    end else begin
                        main_fill--;
                        r.removed = main_words[main_fill];
                        aux_words[aux_fill] = r.removed;
                        aux_fill++;
                    end
                end
                OP_RESTORE: begin
                    // empty aux wins over full main
                    if (aux_fill == 0) begin
                        r.status = STAT_AUX_EMPTY;
                    end else if (main_fill >= DEPTH) begin
                        r.status = STAT_MAIN_FULL;
                    end else begin
                        aux_fill--;
                        r.removed = aux_words[aux_fill];
                        main_words[main_fill] = r.removed;
                        main_fill++;
                    end
                end
                OP_CLEAR: begin
                    main_fill = 0;
                end
                default: begin
                    // spare opcodes do nothing
                end
            endcase

            r.main_valid = (main_fill > 0);
            r.aux_valid  = (aux_fill > 0);
            r.main_top   = r.main_valid ? main_words[main_fill-1] : '0;
            r.aux_top    = r.aux_valid ? aux_words[aux_fill-1] : '0;
            r.main_count = OUT_CNT_W'(main_fill);
            r.aux_count  = OUT_CNT_W'(aux_fill);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on %s at result %0d: expected %h, got %h",
                             name, results_seen, want, got);
            end
        endfunction

        // Check one result word against the oldest prediction
        function void compare_result(logic [M_TDATA_W-1:0] word);
            stack_result_t want;
            stack_result_t got;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d: %h", results_seen, word);
                return;
            end
            want = pending_results.pop_front();

            // unpack, lowest field first
            got.status     = status_t'(word[2:0]);
            got.removed    = word[34:3];
            got.main_top   = word[66:35];
            got.main_valid = word[67];
            got.aux_top    = word[99:68];
            got.aux_valid  = word[100];
            got.main_count = word[105:101];
            got.aux_count  = word[110:106];

            compare_field("status", want.status, got.status);
            compare_field("removed_value", want.removed, got.removed);
            compare_field("main_top", want.main_top, got.main_top);
            compare_field("main_valid", want.main_valid, got.main_valid);
            compare_field("aux_top", want.aux_top, got.aux_top);
            compare_field("aux_valid", want.aux_valid, got.aux_valid);
            compare_field("main_count", want.main_count, got.main_count);
            compare_field("aux_count", want.aux_count, got.aux_count);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function bit failed();
            return (mismatches != 0) || (pending_results.size() != 0);
        endfunction
    endclass

endpackage

// File: dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Stream-level test of the two-stack undo block: directed cases on empty stacks,
// spare opcodes and value extremes, then random operation mixes that push the
// stacks to their limits, with random idling on both sides and drain pauses.
// ---------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import dsus_pkg::*;
    import stack_mirror_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_WORDS = 1350;
    localparam int IDLE_PCT     = 33;
    localparam int SETTLE_CYCLES = 8;

    // opcodes the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef enum int {
        MIX_EVEN,
        MIX_FILL_MAIN,
        MIX_FILL_AUX,
        MIX_RESTORE,
        MIX_DRAIN
    } mix_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    bit          stall_free = 1'b0;
    stack_mirror mirror = new();

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    dual_stack_with_undo_store u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] push_value
        .s_tuser  (s_tuser),   // [2:0] opcode
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // status, removed, main top/valid, aux top/valid, counts
    );

    // Result side: random back-pressure, check at the rising edge
    always @(negedge aclk) begin
        m_tready <= stall_free || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            mirror.compare_result(m_tdata);
    end

    // Send one operation word; returns at the falling edge after acceptance
    task automatic send_word(input logic [OP_W-1:0] op, input logic [S_TDATA_W-1:0] value);
        int gap;
        if (!stall_free && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        mirror.apply_op(op, value);
        @(negedge aclk);
    endtask

    // Hold off until every predicted result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (mirror.pending() != 0) @(negedge aclk);
    endtask

    // Push values: extremes, small numbers and full-range noise
    function automatic logic [S_TDATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            4, 5:    return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // Operation mix per episode, cumulative percent for push..clear
    function automatic logic [OP_W-1:0] pick_op(mix_t mix);
        int cut[5];
        int roll;
        case (mix)
            MIX_FILL_MAIN: cut = '{85, 89, 93, 97, 98};
            MIX_FILL_AUX:  cut = '{48, 52, 95, 97, 98};
            MIX_RESTORE:   cut = '{35, 40, 45, 96, 97};
            MIX_DRAIN:     cut = '{10, 55, 70, 85, 97};
            default:       cut = '{34, 50, 66, 82, 90};
        endcase
        roll = $urandom_range(0, 99);
        if (roll < cut[0]) return OP_PUSH;
        if (roll < cut[1]) return OP_POP;
        if (roll < cut[2]) return OP_MOVE;
        if (roll < cut[3]) return OP_RESTORE;
        if (roll < cut[4]) return OP_CLEAR;
        return OP_W'(OP_SPARE_FIRST + $urandom_range(0, OP_SPARE_LAST - OP_SPARE_FIRST));
    endfunction

    // Main stimulus
    initial begin
        int   words;
        int   span;
        mix_t mix;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty-stack cases and spare opcodes
        send_word(OP_POP, 32'hFFFF_FFFF);
        send_word(OP_MOVE, 32'h0000_0000);
        send_word(OP_RESTORE, 32'hFFFF_FFFF);
        send_word(OP_CLEAR, 32'h0000_0000);
        send_word(OP_SPARE_FIRST, 32'hFFFF_FFFF);
        send_word(OP_W'(OP_SPARE_FIRST + 1), 32'h0000_0000);
        send_word(OP_SPARE_LAST, 32'hFFFF_FFFF);
        // value extremes through push, move, restore and pop
        send_word(OP_PUSH, 32'h8000_0000);
        send_word(OP_PUSH, 32'h7FFF_FFFF);
        send_word(OP_PUSH, 32'hFFFF_FFFF);
        send_word(OP_PUSH, 32'h0000_0000);
        send_word(OP_MOVE, 32'hFFFF_FFFF);
        send_word(OP_MOVE, 32'h0000_0000);
        send_word(OP_RESTORE, 32'h0000_0000);
        send_word(OP_POP, 32'h0000_0000);
        // clear leaves aux alone, then empty it again
        send_word(OP_CLEAR, 32'hFFFF_FFFF);
        send_word(OP_POP, 32'h0000_0000);
        send_word(OP_RESTORE, 32'h0000_0000);
        send_word(OP_RESTORE, 32'h0000_0000);
        send_word(OP_RESTORE, 32'h0000_0000);
        send_word(OP_POP, 32'h0000_0000);

        // let everything come back before the random part
        wait_drained();

        // random episodes, each biased toward one stack condition
        words = 0;
        while (words < RANDOM_WORDS) begin
            mix  = mix_t'($urandom_range(MIX_EVEN, MIX_DRAIN));
            span = $urandom_range(10, 60);
            stall_free = (words >= 500 && words < 700);
            repeat (span) begin
                send_word(pick_op(mix), pick_value());
                words++;
            end
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
        stall_free = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (mirror.failed())
            $display("dual_stack_with_undo_store test failed");
        else
            $display("dual_stack_with_undo_store test passed");
        $finish;
    end

    // Watchdog
    initial begin
        #3ms;
        $display("dual_stack_with_undo_store test failed");
        $finish;
    end

endmodule
